@@ rtl/trq_pkg.sv @@
// Shared widths, command codes and configuration register codes of the typed record queue.
package trq_pkg;

  localparam int KIND_W     = 3;
  localparam int TYPE_W     = 3;
  localparam int DATA_W     = 64;
  localparam int SEQ_W      = 6;
  localparam int OTYPE_W    = 2;
  localparam int TOTAL_W    = 9;
  localparam int TCOUNT_W   = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 7;
  localparam int SIZE_W     = 4;
  localparam int LIMIT_W    = 7;
  localparam int CFG_TYPES  = 4;

  localparam logic [KIND_W-1:0] KIND_PUSH      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ_NEXT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ_IDX  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REWIND    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE0  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT0 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END    = 4'd8;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 4'd8;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

endpackage

@@ rtl/trq_cmd_if.sv @@
// Command channel of the typed record queue: valid, ready and the command fields.
interface trq_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [trq_pkg::KIND_W-1:0]  kind;
  logic [trq_pkg::TYPE_W-1:0]  type_id;
  logic [trq_pkg::DATA_W-1:0]  payload;
  logic [trq_pkg::SEQ_W-1:0]   seq_index;

  modport source (output valid, kind, type_id, payload, seq_index, input ready);
  modport sink   (input valid, kind, type_id, payload, seq_index, output ready);
endinterface

@@ rtl/trq_rsp_if.sv @@
// Result channel of the typed record queue: valid, ready and the result fields.
interface trq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [trq_pkg::OTYPE_W-1:0]   out_type;
  logic [trq_pkg::DATA_W-1:0]    out_payload;
  logic [trq_pkg::TOTAL_W-1:0]   total_count;
  logic [trq_pkg::TCOUNT_W-1:0]  type_count;

  modport source (output valid, ok, out_type, out_payload, total_count, type_count,
                  input ready);
  modport sink   (input valid, ok, out_type, out_payload, total_count, type_count,
                  output ready);
endinterface

@@ rtl/trq_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module trq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/trq_cfg.sv @@
// Configuration registers: per-type payload size and record limit, looked up by type.
module trq_cfg #(
  parameter int MAX_PER_TYPE  = 64,
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [trq_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [trq_pkg::CFG_DATA_W-1:0]            cfg_data,
  input  logic [trq_pkg::TYPE_W-1:0]                type_id,
  output logic [8*PAYLOAD_BYTES-1:0]                keep_mask,
  output logic [$clog2(MAX_PER_TYPE+1)-1:0]         type_limit
);

  localparam int CNT_W = $clog2(MAX_PER_TYPE + 1);
  localparam int LW    = (CNT_W > trq_pkg::LIMIT_W) ? CNT_W : trq_pkg::LIMIT_W;

  logic [trq_pkg::SIZE_W-1:0]  size_reg  [trq_pkg::CFG_TYPES];
  logic [trq_pkg::LIMIT_W-1:0] limit_reg [trq_pkg::CFG_TYPES];

  logic                        cfg_type;
  logic [trq_pkg::SIZE_W-1:0]  bytes_raw;
  logic [trq_pkg::SIZE_W-1:0]  bytes;
  logic [LW-1:0]               lim_raw;
  logic [LW-1:0]               lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < trq_pkg::CFG_TYPES; i++) begin
        size_reg[i]  <= trq_pkg::SIZE_RESET;
        limit_reg[i] <= trq_pkg::LIMIT_RESET;
      end
    end else if (cfg_we) begin
      if (cfg_index < trq_pkg::CFG_LIMIT0) begin
        size_reg[cfg_index[1:0]] <= cfg_data[trq_pkg::SIZE_W-1:0];
      end else if (cfg_index < trq_pkg::CFG_END) begin
        limit_reg[cfg_index[1:0]] <= cfg_data[trq_pkg::LIMIT_W-1:0];
      end
    end
  end

  // Types without a register of their own keep the full payload and the full limit.
  assign cfg_type  = type_id < trq_pkg::TYPE_W'(trq_pkg::CFG_TYPES);
  assign bytes_raw = cfg_type ? size_reg[type_id[1:0]] : trq_pkg::SIZE_W'(PAYLOAD_BYTES);
  assign bytes     = (bytes_raw > trq_pkg::SIZE_W'(PAYLOAD_BYTES)) ?
                     trq_pkg::SIZE_W'(PAYLOAD_BYTES) : bytes_raw;
  assign lim_raw   = cfg_type ? LW'(limit_reg[type_id[1:0]]) : LW'(MAX_PER_TYPE);
  assign lim       = (lim_raw > LW'(MAX_PER_TYPE)) ? LW'(MAX_PER_TYPE) : lim_raw;
  assign type_limit = CNT_W'(lim);

  always_comb begin
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      keep_mask[8*b +: 8] = (trq_pkg::SIZE_W'(b) < bytes) ? 8'hFF : 8'h00;
    end
  end

endmodule

@@ rtl/typed_record_queue.sv @@
// Typed record queue: append-only record store with per-type limits and indexed reads.
// Push, rewind, clear, unknown commands and refused reads give their result in the cycle
// after the command transfer. A read-next waits on the registered read of the slot memory;
// an indexed read first waits on the index memory and then on the slot memory.
// Commands are handled one at a time; a new one is taken only when the sequencer is idle.
// Reset (synchronous, active high) clears the counters at once; sizes return to 8, limits to 64.
module typed_record_queue #(
  parameter int TYPE_COUNT    = 4,
  parameter int MAX_PER_TYPE  = 64,
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  trq_cmd_if.sink                        cmd,
  trq_rsp_if.source                      rsp,
  input  logic                           cfg_we,
  input  logic [trq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [trq_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOTS   = TYPE_COUNT * MAX_PER_TYPE;
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TOT_W   = $clog2(SLOTS + 1);
  localparam int CNT_W   = $clog2(MAX_PER_TYPE + 1);
  localparam int PAY_W   = 8 * PAYLOAD_BYTES;
  localparam int SLOT_W  = trq_pkg::OTYPE_W + PAY_W;
  localparam int TID_W   = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
  localparam int CMP_W   = (CNT_W > trq_pkg::SEQ_W) ? CNT_W : trq_pkg::SEQ_W;

  // Sequencer states: idle, waiting on the index memory, waiting on the slot memory.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_IDX  = 2'd1;
  localparam logic [1:0] ST_SLOT = 2'd2;

  logic [1:0]         state;
  logic [TOT_W-1:0]   written_total;
  logic [TOT_W-1:0]   read_total;
  logic [CNT_W-1:0]   type_cnt [TYPE_COUNT];

  logic               out_valid;
  logic               res_ok;
  logic [trq_pkg::OTYPE_W-1:0] res_type;
  logic [PAY_W-1:0]   res_payload;
  logic [TOT_W-1:0]   res_total;
  logic [CNT_W-1:0]   res_tcount;

  logic [PAY_W-1:0]   keep_mask;
  logic [CNT_W-1:0]   type_limit;

  logic               in_fire;
  logic               type_ok;
  logic [TID_W-1:0]   t_idx;
  logic [CNT_W-1:0]   cnt_sel;
  logic               push_can;
  logic               do_push;
  logic               idx_hit;
  logic               next_hit;
  logic [SLOT_AW-1:0] idx_off;
  logic [SLOT_AW-1:0] idx_addr;
  logic [SLOT_AW-1:0] idx_rdata;
  logic [SLOT_AW-1:0] slot_raddr;
  logic [SLOT_W-1:0]  slot_wdata;
  logic [SLOT_W-1:0]  slot_rdata;

  logic               imm_ok;
  logic [TOT_W-1:0]   imm_total;
  logic [CNT_W-1:0]   imm_tcount;
  logic               wait_slot;
  logic               wait_idx;
  logic               res_load;

  trq_cfg #(
    .MAX_PER_TYPE  (MAX_PER_TYPE),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .type_id    (cmd.type_id),
    .keep_mask  (keep_mask),
    .type_limit (type_limit)
  );

  // A new command is taken only when the sequencer is idle and the result register is
  // empty or being emptied in the same cycle, so one command is in flight at a time.
  assign cmd.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign in_fire   = cmd.valid && cmd.ready;

  assign type_ok  = {1'b0, cmd.type_id} < (trq_pkg::TYPE_W + 1)'(TYPE_COUNT);
  assign t_idx    = cmd.type_id[TID_W-1:0];
  assign cnt_sel  = type_ok ? type_cnt[t_idx] : '0;
  assign push_can = type_ok && (cnt_sel < type_limit) && (written_total < TOT_W'(SLOTS));
  assign do_push  = in_fire && (cmd.kind == trq_pkg::KIND_PUSH) && push_can;
  assign idx_hit  = type_ok && (CMP_W'(cmd.seq_index) < CMP_W'(cnt_sel));
  assign next_hit = read_total < written_total;

  // The index memory holds, per type, a row of MAX_PER_TYPE slot numbers in arrival order.
  // A push writes the next entry of its row; an indexed read fetches entry seq_index.
  assign idx_off  = (cmd.kind == trq_pkg::KIND_PUSH) ? SLOT_AW'(cnt_sel) :
                    SLOT_AW'(cmd.seq_index);
  assign idx_addr = SLOT_AW'(t_idx * MAX_PER_TYPE) + idx_off;

  trq_ram #(
    .WIDTH (SLOT_AW),
    .DEPTH (SLOTS)
  ) u_idx_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (idx_addr),
    .wdata (written_total[SLOT_AW-1:0]),
    .raddr (idx_addr),
    .rdata (idx_rdata)
  );

  // The slot memory holds type and trimmed payload of each record in arrival order. It is
  // read at the sequential read pointer, or at the slot number that the index memory gave.
  assign slot_wdata = {cmd.type_id[trq_pkg::OTYPE_W-1:0], cmd.payload[PAY_W-1:0] & keep_mask};
  assign slot_raddr = (state == ST_IDX) ? idx_rdata : read_total[SLOT_AW-1:0];

  trq_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (written_total[SLOT_AW-1:0]),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Decode of the command in the transfer cycle. Commands that do not read a record are
  // complete here; a successful read waits on the memories instead.
  always_comb begin
    imm_ok     = 1'b0;
    imm_total  = written_total;
    imm_tcount = cnt_sel;
    wait_slot  = 1'b0;
    wait_idx   = 1'b0;
    case (cmd.kind)
      trq_pkg::KIND_PUSH: begin
        imm_ok = push_can;
        if (push_can) begin
          imm_total  = TOT_W'(written_total + 1'b1);
          imm_tcount = CNT_W'(cnt_sel + 1'b1);
        end
      end
      trq_pkg::KIND_READ_NEXT: begin
        wait_slot = next_hit;
      end
      trq_pkg::KIND_READ_IDX: begin
        wait_idx = idx_hit;
      end
      trq_pkg::KIND_REWIND: begin
        imm_ok = 1'b1;
      end
      trq_pkg::KIND_CLEAR: begin
        imm_ok     = 1'b1;
        imm_total  = '0;
        imm_tcount = '0;
      end
      default: begin
        imm_ok = 1'b0;
      end
    endcase
  end

  // The result register is loaded by a command that completes at its transfer, or by a read
  // whose record has just come out of the slot memory.
  assign res_load = (in_fire && !wait_slot && !wait_idx) || (state == ST_SLOT);

  // Sequencer, counters and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      written_total <= '0;
      read_total    <= '0;
      for (int i = 0; i < TYPE_COUNT; i++) begin
        type_cnt[i] <= '0;
      end
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (wait_slot) begin
              read_total <= TOT_W'(read_total + 1'b1);
              state      <= ST_SLOT;
            end else if (wait_idx) begin
              state <= ST_IDX;
            end
            if (do_push) begin
              written_total  <= TOT_W'(written_total + 1'b1);
              type_cnt[t_idx] <= CNT_W'(cnt_sel + 1'b1);
            end
            if (cmd.kind == trq_pkg::KIND_REWIND) begin
              read_total <= '0;
            end
            if (cmd.kind == trq_pkg::KIND_CLEAR) begin
              read_total    <= '0;
              written_total <= '0;
              for (int i = 0; i < TYPE_COUNT; i++) begin
                type_cnt[i] <= '0;
              end
            end
          end
        end
        ST_IDX: begin
          state <= ST_SLOT;
        end
        ST_SLOT: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result fields. Counts are captured at the transfer; a read fills in the record when the
  // slot memory returns it.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_ok      <= imm_ok;
      res_type    <= '0;
      res_payload <= '0;
      res_total   <= imm_total;
      res_tcount  <= imm_tcount;
    end else if (state == ST_SLOT) begin
      res_ok      <= 1'b1;
      res_type    <= slot_rdata[SLOT_W-1 -: trq_pkg::OTYPE_W];
      res_payload <= slot_rdata[PAY_W-1:0];
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.ok          = res_ok;
  assign rsp.out_type    = res_type;
  assign rsp.out_payload = trq_pkg::DATA_W'(res_payload);
  assign rsp.total_count = trq_pkg::TOTAL_W'(res_total);
  assign rsp.type_count  = trq_pkg::TCOUNT_W'(res_tcount);

  // The sequential read pointer never passes the number of records written.
  a_read_behind: assert property (@(posedge clk) disable iff (rst)
    read_total <= written_total)
    else $error("read pointer passed the write count");

  // The write count never exceeds the number of slots.
  a_slots_bound: assert property (@(posedge clk) disable iff (rst)
    written_total <= TOT_W'(SLOTS))
    else $error("write count exceeds slot count");

  // While a read waits on memory, no result is pending on the output.
  a_busy_empty: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !out_valid)
    else $error("result pending while a read is in flight");

  // An accepted push advances the write count by exactly one.
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    do_push |=> (written_total == $past(written_total) + 1'b1))
    else $error("push did not advance the write count");

endmodule
